### sv/tbga_pkg.sv
// Package: fixed-point format constants and datapath widths for the third-body accumulator.
package tbga_pkg;

    localparam int ACC_FRAC_BITS = 52;
    localparam int NUM_SHIFT     = ACC_FRAC_BITS + 8;

    localparam int POS_W  = 48;
    localparam int MAG_W  = POS_W + 1;
    localparam int GM_W   = 64;
    localparam int ACC_W  = 64;
    localparam int N2_W   = 102;
    localparam int ROOT_W = 51;
    localparam int REM_W  = 54;
    localparam int DEN_W  = 153;
    localparam int Q_W    = 63;
    localparam int DW     = 216;
    localparam int MP_W   = 64;
    localparam int CNT_W  = 6;

    localparam logic [CNT_W-1:0] MAG_STEPS  = CNT_W'(MAG_W - 1);
    localparam logic [CNT_W-1:0] ROOT_STEPS = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(Q_W);

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic [1:0] MK_SQ   = 2'd0;
    localparam logic [1:0] MK_CUBE = 2'd1;
    localparam logic [1:0] MK_NUM  = 2'd2;

endpackage

### sv/third_body_gravity_accumulator.sv
// Top level: third-body perturbation accumulator on one shared wide adder.
//
//  channel | direction | ports                                    | request
//  s_      | in        | sat_pos, body_rel, gravity_param, last   | one perturbing body
//  m_      | out       | acc_x/y/z, fault                         | summed acceleration
//
// Each body is worked through as two vectors. Per vector that is
// three 49-step squares, a 51-step square root, a 51-step cube and three 49-step
// products, each followed by a 64-step restoring divide. All of it runs through
// the single 217-bit add/subtract unit.
// s_ready is high only when the sequencer is idle. A zero norm ends the
// body early with the fault flag set; a clamped quotient ends only its divide early.
// The result register is separate, so a new body runs while a result waits;
// the last body holds in its final step until the result register is free.
// aresetn is synchronous, active low; it clears the sums and the fault flag.
module third_body_gravity_accumulator
    import tbga_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [POS_W-1:0] s_sat_pos_x,
    input  logic signed [POS_W-1:0] s_sat_pos_y,
    input  logic signed [POS_W-1:0] s_sat_pos_z,
    input  logic signed [POS_W-1:0] s_body_rel_x,
    input  logic signed [POS_W-1:0] s_body_rel_y,
    input  logic signed [POS_W-1:0] s_body_rel_z,
    input  logic [GM_W-1:0]         s_gravity_param,
    input  logic                    s_last_body,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [ACC_W-1:0] m_acc_x,
    output logic signed [ACC_W-1:0] m_acc_y,
    output logic signed [ACC_W-1:0] m_acc_z,
    output logic                    m_fault
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_LOADV  = 5'd1;
    localparam logic [4:0] ST_SQSET  = 5'd2;
    localparam logic [4:0] ST_MUL    = 5'd3;
    localparam logic [4:0] ST_SQADD  = 5'd4;
    localparam logic [4:0] ST_NCHK   = 5'd5;
    localparam logic [4:0] ST_SQRT   = 5'd6;
    localparam logic [4:0] ST_RSQ    = 5'd7;
    localparam logic [4:0] ST_NUMSET = 5'd8;
    localparam logic [4:0] ST_DIVSET = 5'd9;
    localparam logic [4:0] ST_DIV    = 5'd10;
    localparam logic [4:0] ST_PART   = 5'd11;
    localparam logic [4:0] ST_TERM   = 5'd12;
    localparam logic [4:0] ST_ACC    = 5'd13;
    localparam logic [4:0] ST_FIN    = 5'd14;

    logic [4:0]             state_reg;
    logic                   vec_reg;
    logic [1:0]             axis_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [1:0]             kind_reg;

    logic [POS_W-1:0]       sat_reg [3];
    logic [POS_W-1:0]       rel_reg [3];
    logic [GM_W-1:0]        g_reg;
    logic                   last_reg;

    logic [MAG_W-1:0]       mag_reg [3];
    logic [2:0]             neg_reg;

    logic [DW-1:0]          p_reg;
    logic [DW-1:0]          m_reg;
    logic [MP_W-1:0]        mp_reg;
    logic [N2_W-1:0]        n2_reg;
    logic [N2_W-1:0]        nsave_reg;
    logic [ROOT_W-1:0]      root_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [Q_W-1:0]         q_reg;
    logic [ACC_W-1:0]       pa_reg [3];
    logic [ACC_W-1:0]       pb_reg [3];
    logic [ACC_W-1:0]       t_reg;
    logic [ACC_W-1:0]       acc_reg [3];
    logic                   fault_reg;

    logic                   m_valid_reg;
    logic [ACC_W-1:0]       out_x_reg;
    logic [ACC_W-1:0]       out_y_reg;
    logic [ACC_W-1:0]       out_z_reg;
    logic                   out_fault_reg;

    // shared add/subtract unit
    logic [DW:0]            alu_a;
    logic [DW:0]            alu_b;
    logic                   alu_sub;
    logic [DW:0]            alu_sum;
    logic                   alu_lt;
    logic                   alu_ovf;
    logic [ACC_W-1:0]       alu_sat;

    logic [MAG_W-1:0]       v_val [3];
    logic [MAG_W-1:0]       v_mag [3];
    logic                   fin_go;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_acc_x  = out_x_reg;
    assign m_acc_y  = out_y_reg;
    assign m_acc_z  = out_z_reg;
    assign m_fault  = out_fault_reg;

    assign fin_go = !m_valid_reg || m_ready;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (vec_reg) begin
                v_val[i] = {sat_reg[i][POS_W-1], sat_reg[i]}
                         + {rel_reg[i][POS_W-1], rel_reg[i]};
            end else begin
                v_val[i] = {rel_reg[i][POS_W-1], rel_reg[i]};
            end
            v_mag[i] = v_val[i][MAG_W-1] ? (~v_val[i] + MAG_W'(1)) : v_val[i];
        end
    end

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_MUL: begin
                alu_a = {1'b0, p_reg[DW-2:0], 1'b0};
                alu_b = mp_reg[MP_W-1] ? {1'b0, m_reg} : '0;
            end
            ST_SQADD: begin
                alu_a = (DW+1)'(n2_reg);
                alu_b = {1'b0, p_reg};
            end
            ST_SQRT: begin
                alu_a   = (DW+1)'({rem_reg[REM_W-3:0], n2_reg[N2_W-1 -: 2]});
                alu_b   = (DW+1)'({root_reg, 2'b01});
                alu_sub = 1'b1;
            end
            ST_RSQ: begin
                alu_a   = (DW+1)'(nsave_reg);
                alu_b   = (DW+1)'(rem_reg);
                alu_sub = 1'b1;
            end
            ST_DIV: begin
                alu_a   = {1'b0, p_reg};
                alu_b   = {1'b0, m_reg};
                alu_sub = 1'b1;
            end
            ST_PART: begin
                alu_b   = (DW+1)'(q_reg);
                alu_sub = 1'b1;
            end
            ST_TERM: begin
                alu_a   = {{(DW+1-ACC_W){pa_reg[axis_reg][ACC_W-1]}}, pa_reg[axis_reg]};
                alu_b   = {{(DW+1-ACC_W){pb_reg[axis_reg][ACC_W-1]}}, pb_reg[axis_reg]};
                alu_sub = 1'b1;
            end
            ST_ACC: begin
                alu_a = {{(DW+1-ACC_W){acc_reg[axis_reg][ACC_W-1]}}, acc_reg[axis_reg]};
                alu_b = {{(DW+1-ACC_W){t_reg[ACC_W-1]}}, t_reg};
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
        alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + (DW+1)'(alu_sub);
        alu_lt  = alu_sum[DW];
        alu_ovf = (alu_sum[DW:ACC_W-1] != {(DW-ACC_W+2){alu_sum[ACC_W-1]}});
        alu_sat = alu_sum[DW] ? ACC_MIN : ACC_MAX;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && last_reg && fin_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fault_reg   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        sat_reg[0] <= s_sat_pos_x;
                        sat_reg[1] <= s_sat_pos_y;
                        sat_reg[2] <= s_sat_pos_z;
                        rel_reg[0] <= s_body_rel_x;
                        rel_reg[1] <= s_body_rel_y;
                        rel_reg[2] <= s_body_rel_z;
                        g_reg      <= s_gravity_param;
                        last_reg   <= s_last_body;
                        vec_reg    <= 1'b0;
                        state_reg  <= ST_LOADV;
                    end
                end
                ST_LOADV: begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= v_mag[i];
                        neg_reg[i] <= v_val[i][MAG_W-1];
                    end
                    n2_reg    <= '0;
                    axis_reg  <= 2'd0;
                    state_reg <= ST_SQSET;
                end
                ST_SQSET: begin
                    m_reg     <= DW'(mag_reg[axis_reg]);
                    mp_reg    <= {mag_reg[axis_reg], (MP_W-MAG_W)'(0)};
                    p_reg     <= '0;
                    cnt_reg   <= MAG_STEPS;
                    kind_reg  <= MK_SQ;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    p_reg   <= alu_sum[DW-1:0];
                    mp_reg  <= {mp_reg[MP_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0) begin
                        case (kind_reg)
                            MK_SQ: state_reg <= ST_SQADD;
                            MK_CUBE: begin
                                den_reg   <= alu_sum[DEN_W-1:0];
                                axis_reg  <= 2'd0;
                                state_reg <= ST_NUMSET;
                            end
                            default: state_reg <= ST_DIVSET;
                        endcase
                    end
                end
                ST_SQADD: begin
                    n2_reg <= alu_sum[N2_W-1:0];
                    if (axis_reg == 2'd2) begin
                        state_reg <= ST_NCHK;
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_SQSET;
                    end
                end
                ST_NCHK: begin
                    if (n2_reg == '0) begin
                        fault_reg <= 1'b1;
                        state_reg <= ST_FIN;
                    end else begin
                        nsave_reg <= n2_reg;
                        root_reg  <= '0;
                        rem_reg   <= '0;
                        cnt_reg   <= ROOT_STEPS;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (!alu_lt) begin
                        rem_reg  <= alu_sum[REM_W-1:0];
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                    end else begin
                        rem_reg  <= alu_a[REM_W-1:0];
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                    end
                    n2_reg  <= {n2_reg[N2_W-3:0], 2'b00};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0) begin
                        state_reg <= ST_RSQ;
                    end
                end
                ST_RSQ: begin
                    // root^2 = n^2 - remainder
                    m_reg     <= DW'(alu_sum[N2_W-1:0]);
                    mp_reg    <= {root_reg, (MP_W-ROOT_W)'(0)};
                    p_reg     <= '0;
                    cnt_reg   <= ROOT_STEPS;
                    kind_reg  <= MK_CUBE;
                    state_reg <= ST_MUL;
                end
                ST_NUMSET: begin
                    m_reg     <= DW'(g_reg);
                    mp_reg    <= {mag_reg[axis_reg], (MP_W-MAG_W)'(0)};
                    p_reg     <= '0;
                    cnt_reg   <= MAG_STEPS;
                    kind_reg  <= MK_NUM;
                    state_reg <= ST_MUL;
                end
                ST_DIVSET: begin
                    p_reg     <= p_reg << NUM_SHIFT;
                    m_reg     <= DW'(den_reg) << Q_W;
                    q_reg     <= '0;
                    cnt_reg   <= DIV_STEPS;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    m_reg   <= {1'b0, m_reg[DW-1:1]};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == DIV_STEPS && !alu_lt) begin
                        // quotient reaches 2^63: clamp
                        q_reg     <= '1;
                        fault_reg <= 1'b1;
                        state_reg <= ST_PART;
                    end else begin
                        if (!alu_lt) begin
                            p_reg <= alu_sum[DW-1:0];
                        end
                        q_reg <= {q_reg[Q_W-2:0], !alu_lt};
                        if (cnt_reg == '0) begin
                            state_reg <= ST_PART;
                        end
                    end
                end
                ST_PART: begin
                    if (vec_reg) begin
                        pb_reg[axis_reg] <= neg_reg[axis_reg] ? alu_sum[ACC_W-1:0]
                                                              : {1'b0, q_reg};
                    end else begin
                        pa_reg[axis_reg] <= neg_reg[axis_reg] ? alu_sum[ACC_W-1:0]
                                                              : {1'b0, q_reg};
                    end
                    if (axis_reg == 2'd2) begin
                        axis_reg <= 2'd0;
                        if (vec_reg) begin
                            state_reg <= ST_TERM;
                        end else begin
                            vec_reg   <= 1'b1;
                            state_reg <= ST_LOADV;
                        end
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_NUMSET;
                    end
                end
                ST_TERM: begin
                    if (alu_ovf) begin
                        t_reg     <= alu_sat;
                        fault_reg <= 1'b1;
                    end else begin
                        t_reg <= alu_sum[ACC_W-1:0];
                    end
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (alu_ovf) begin
                        acc_reg[axis_reg] <= alu_sat;
                        fault_reg         <= 1'b1;
                    end else begin
                        acc_reg[axis_reg] <= alu_sum[ACC_W-1:0];
                    end
                    if (axis_reg == 2'd2) begin
                        state_reg <= ST_FIN;
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_TERM;
                    end
                end
                ST_FIN: begin
                    if (!last_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (fin_go) begin
                        out_x_reg     <= acc_reg[0];
                        out_y_reg     <= acc_reg[1];
                        out_z_reg     <= acc_reg[2];
                        out_fault_reg <= fault_reg;
                        fault_reg     <= 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            acc_reg[i] <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_LOADV))
        else $error("accepted request did not start a body");

    a_sqrt_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RSQ) |-> (rem_reg <= {root_reg, 1'b0}))
        else $error("square root remainder out of range");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && last_reg && fin_go) |=>
            (m_valid && acc_reg[0] == '0 && acc_reg[1] == '0 && acc_reg[2] == '0
             && !fault_reg))
        else $error("result emitted without clearing the sums");

    a_no_sum_before_both: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TERM) |-> vec_reg)
        else $error("term formed before both vectors were done");

endmodule

### verif/tbga_checker.sv
// Checker: predicts the summed third-body acceleration and compares each result.
module tbga_checker
    import tbga_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic signed [POS_W-1:0] s_sat_pos_x,
    input  logic signed [POS_W-1:0] s_sat_pos_y,
    input  logic signed [POS_W-1:0] s_sat_pos_z,
    input  logic signed [POS_W-1:0] s_body_rel_x,
    input  logic signed [POS_W-1:0] s_body_rel_y,
    input  logic signed [POS_W-1:0] s_body_rel_z,
    input  logic [GM_W-1:0]         s_gravity_param,
    input  logic                    s_last_body,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic signed [ACC_W-1:0] m_acc_x,
    input  logic signed [ACC_W-1:0] m_acc_y,
    input  logic signed [ACC_W-1:0] m_acc_z,
    input  logic                    m_fault,
    output int                      errors,
    output int                      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [POS_W:0] vec_t [3];
    typedef logic signed [ACC_W-1:0] acc_t [3];

    typedef struct {
        logic signed [ACC_W-1:0] acc [3];
        logic                    fault;
    } accel_t;

    accel_t            accel_q[$];
    logic signed [ACC_W-1:0] sum_acc [3];
    logic              sum_fault;

    assign outstanding = accel_q.size();

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b,
                                                        inout bit sat);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s > $signed({1'b0, ACC_MAX})) begin
            sat = 1;
            return ACC_MAX;
        end
        if (s < $signed({1'b1, ACC_MIN})) begin
            sat = 1;
            return ACC_MIN;
        end
        return s[ACC_W-1:0];
    endfunction

    // sign(v)*floor(g*2^(F+8)*|v|/n^3) per axis; returns 0 on zero norm
    function automatic bit gravity_part(input vec_t v, input logic [GM_W-1:0] g,
                                        output acc_t p, inout bit sat);
        logic [255:0] n2, c, den, num, q;
        logic [ROOT_W-1:0] root, cand;
        logic [POS_W:0] m [3];
        n2 = '0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i][POS_W] ? -v[i] : v[i];
            n2 += 256'(m[i]) * 256'(m[i]);
        end
        if (n2 == 0) return 0;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            cand = root | (ROOT_W'(1) << b);
            c = 256'(cand) * 256'(cand);
            if (c <= n2) root = cand;
        end
        den = 256'(root) * 256'(root) * 256'(root);
        for (int i = 0; i < 3; i++) begin
            num = (256'(g) * 256'(m[i])) << NUM_SHIFT;
            q = num / den;
            if (q > 256'(ACC_MAX)) begin
                sat = 1;
                q = 256'(ACC_MAX);
            end
            p[i] = v[i][POS_W] ? -ACC_W'(q) : ACC_W'(q);
        end
        return 1;
    endfunction

    function automatic void accumulate_body();
        vec_t rel, s;
        acc_t pa, pb;
        bit sat;
        logic signed [ACC_W-1:0] term;
        accel_t r;
        sat = 0;
        rel[0] = s_body_rel_x;
        rel[1] = s_body_rel_y;
        rel[2] = s_body_rel_z;
        s[0] = (POS_W+1)'(s_sat_pos_x) + rel[0];
        s[1] = (POS_W+1)'(s_sat_pos_y) + rel[1];
        s[2] = (POS_W+1)'(s_sat_pos_z) + rel[2];
        if (gravity_part(rel, s_gravity_param, pa, sat) &&
            gravity_part(s, s_gravity_param, pb, sat)) begin
            for (int i = 0; i < 3; i++) begin
                term = sat_add(pa[i], -pb[i], sat);
                sum_acc[i] = sat_add(sum_acc[i], term, sat);
            end
        end else begin
            sum_fault = 1;
        end
        if (sat) sum_fault = 1;
        if (s_last_body) begin
            r.acc = sum_acc;
            r.fault = sum_fault;
            accel_q.push_back(r);
            sum_acc = '{default: '0};
            sum_fault = 0;
        end
    endfunction

    always @(posedge aclk) begin
        accel_t e;
        if (!aresetn) begin
            sum_acc = '{default: '0};
            sum_fault = 0;
            errors = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (accel_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result x=%0d", m_acc_x);
                end else begin
                    e = accel_q.pop_front();
                    if (e.acc[0] !== m_acc_x || e.acc[1] !== m_acc_y ||
                        e.acc[2] !== m_acc_z || e.fault !== m_fault) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp %0d %0d %0d f%0b got %0d %0d %0d f%0b",
                                     e.acc[0], e.acc[1], e.acc[2], e.fault,
                                     m_acc_x, m_acc_y, m_acc_z, m_fault);
                    end
                end
            end
            if (s_valid && s_ready) accumulate_body();
        end
    end
endmodule

### verif/tb_third_body_gravity_accumulator.sv
// Testbench top: drives perturbing-body requests and gives the verdict.
module tb_third_body_gravity_accumulator;
    import tbga_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [POS_W-1:0] s_sat_pos_x = 0, s_sat_pos_y = 0, s_sat_pos_z = 0;
    logic signed [POS_W-1:0] s_body_rel_x = 0, s_body_rel_y = 0, s_body_rel_z = 0;
    logic [GM_W-1:0] s_gravity_param = 0;
    logic s_last_body = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [ACC_W-1:0] m_acc_x, m_acc_y, m_acc_z;
    logic m_fault;
    int errors, outstanding;
    int rdy_gap = 0;
    bit steady = 0;

    localparam logic signed [POS_W-1:0] PMAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] PMIN = {1'b1, {(POS_W-1){1'b0}}};

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    third_body_gravity_accumulator i_dut (.*);

    tbga_checker i_chk (.*);

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 5);
        return $urandom_range(20, 300);
    endfunction

    always @(negedge aclk) begin
        if (rdy_gap > 0) begin
            m_ready <= 1'b0;
            rdy_gap <= rdy_gap - 1;
        end else begin
            m_ready <= 1'b1;
            rdy_gap <= pick_gap();
        end
    end

    task automatic send_body(input logic signed [POS_W-1:0] sx, sy, sz, rx, ry, rz,
                             input logic [GM_W-1:0] g, input logic last);
        int gap;
        s_sat_pos_x = sx; s_sat_pos_y = sy; s_sat_pos_z = sz;
        s_body_rel_x = rx; s_body_rel_y = ry; s_body_rel_z = rz;
        s_gravity_param = g;
        s_last_body = last;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    function automatic logic signed [POS_W-1:0] rnd_pos(input int bits);
        logic [POS_W-1:0] v;
        v = POS_W'({$urandom, $urandom});
        if (bits < POS_W) v = $signed(v) >>> (POS_W - bits);
        return v;
    endfunction

    task automatic random_body(input logic last);
        logic signed [POS_W-1:0] sx, sy, sz, rx, ry, rz;
        logic [GM_W-1:0] g;
        int mode;
        mode = $urandom_range(0, 99);
        sx = rnd_pos(25); sy = rnd_pos(25); sz = rnd_pos(25);
        rx = rnd_pos(40); ry = rnd_pos(40); rz = rnd_pos(40);
        g = {$urandom, $urandom} >> $urandom_range(8, 30);
        if (mode < 25) begin
            sx = rnd_pos(POS_W); sy = rnd_pos(POS_W); sz = rnd_pos(POS_W);
            rx = rnd_pos(POS_W); ry = rnd_pos(POS_W); rz = rnd_pos(POS_W);
            g = {$urandom, $urandom};
        end else if (mode < 33) begin
            rx = 0; ry = 0; rz = 0;
        end else if (mode < 38) begin
            rx = -sx; ry = -sy; rz = -sz;
        end else if (mode < 48) begin
            rx = rnd_pos(4); ry = rnd_pos(4); rz = rnd_pos(4);
            g = {$urandom, $urandom} >> $urandom_range(0, 63);
        end else if (mode < 52) begin
            g = 0;
        end
        send_body(sx, sy, sz, rx, ry, rz, g, last);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        send_body(1000, 0, 0, 500, 0, 0, 64'd1 << 40, 1'b1);
        send_body(7000000, -3000, 12, 0, 0, 0, 64'd12345, 1'b1);
        send_body(5, 6, 7, -5, -6, -7, 64'd999, 1'b1);
        send_body(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, '1, 1'b1);
        send_body(PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, '1, 1'b1);
        send_body(PMIN, PMAX, 0, PMAX, PMIN, 1, '1, 1'b0);
        send_body(0, 0, 1, 1, 0, 0, '1, 1'b1);
        send_body(0, 0, -1, -1, 0, 0, '1, 1'b0);
        send_body(0, 0, -1, -1, 0, 0, '1, 1'b0);
        send_body(0, 0, -1, -1, 0, 0, '1, 1'b1);
        send_body(100, 200, 300, 400, 500, 600, 0, 1'b1);
        send_body(-7000000, 1, 2, 3, -4, 5, 64'h8000_0000_0000_0000, 1'b0);
        send_body(6000000, 1, 2, 384000000, -4, 5, 64'd1 << 50, 1'b0);
        send_body(6000000, 1, 2, -PMAX, PMAX, 7, 64'd1 << 60, 1'b1);
        send_body(PMAX, 0, 0, 1, 0, 0, 64'd3, 1'b1);
        for (int n = 0; n < 1900; n++) begin
            if (n == 400) steady = 1;
            if (n == 600) steady = 0;
            if (n == 1000) begin
                s_valid = 1'b0;
                wait (outstanding == 0);
                @(negedge aclk);
            end
            random_body(n == 1899 || $urandom_range(0, 3) == 0);
        end
        s_valid = 1'b0;
        wait (outstanding == 0);
        repeat (1500) @(posedge aclk);
        if (errors == 0) $display("tb_third_body_gravity_accumulator: PASS");
        else $display("tb_third_body_gravity_accumulator: FAIL");
        $finish;
    end

    initial begin
        #200ms;
        $display("tb_third_body_gravity_accumulator: FAIL");
        $finish;
    end
endmodule
